// File: src/bsrc_pkg.sv
// shared constants, codes and types of the banker's safety and request check engine
`default_nettype none

package bsrc_pkg;

    // table geometry
    localparam int NUM_PROCS = 8;
    localparam int NUM_RES   = 4;

    // field widths, fixed by the interface
    localparam int PROC_W  = 3;
    localparam int RES_W   = 2;
    localparam int AMT_W   = 8;
    localparam int KIND_W  = 2;
    localparam int TYPE_W  = 3;
    localparam int WORK_W  = 11;
    localparam int PCNT_W  = 4;
    localparam int RCNT_W  = 3;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam int TAB_DEPTH = NUM_PROCS * NUM_RES;
    localparam int ADDR_W    = $clog2(TAB_DEPTH);

    localparam logic [WORK_W-1:0] WORK_MAX = {WORK_W{1'b1}};

    // register index decoded from paddr
    localparam logic CFG_PROC_COUNT = 1'b0;
    localparam logic CFG_RES_COUNT  = 1'b1;

    typedef enum logic [TYPE_W-1:0] {
        REQ_LOAD_ALLOC = 3'd0,
        REQ_LOAD_MAX   = 3'd1,
        REQ_SET_AVAIL  = 3'd2,
        REQ_SAFETY     = 3'd3,
        REQ_STAGE      = 3'd4,
        REQ_SUBMIT     = 3'd5
    } req_type_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_SEQ    = 2'd0,
        KIND_UNSAFE = 2'd1,
        KIND_REQ    = 2'd2
    } res_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIT_RD,
        ST_FIT_EV,
        ST_ADD_RD,
        ST_ADD_EV,
        ST_PASS_END,
        ST_EMIT,
        ST_REQ_RD,
        ST_REQ_EV,
        ST_UPD_RD,
        ST_UPD_EV
    } bsrc_state_t;

    // shared element unit results
    typedef struct packed {
        logic              fits;
        logic              req_ok;
        logic [WORK_W-1:0] work_sum;
        logic [AMT_W-1:0]  alloc_sum;
        logic [AMT_W-1:0]  avail_diff;
    } bsrc_alu_res_t;

endpackage

`default_nettype wire

// File: src/bankers_safety_and_request_check_core.sv
// top level of the banker's safety and request check engine
`default_nettype none

// banker's algorithm engine for deadlock avoidance
// requests enter on start/req_type/proc_index/res_index/amount and are taken
// when start is high and busy is low; results leave on result_valid with
// result_kind/proc_out/granted/last, each shown for exactly one cycle
// loads, available writes and staging give no result and leave the engine idle,
// so one of them can be taken every cycle
// a safety check walks the allocation and max-claim memories one element
// at a time through a single shared compare/add unit: each visited process
// has a scan step, a read and an evaluate step per resource for the fit test
// (stopping at the first resource that does not fit) and another read and
// evaluate per resource to add its allocation to work; passes repeat until
// every process is finished or a pass finds none, then the safe sequence
// streams out one entry per cycle (or one unsafe verdict)
// a submit reads and evaluates each resource for the check, then reads and
// updates each resource; its verdict shows in the cycle after the last evaluation
// the receiver cannot stall: results are strobed and never held
// reset clears the sequencer, the work counts, finished flags and staged
// request, and sets proc_count to 8 and res_count to 4; the memories and
// available counts hold nothing defined until written
module bankers_safety_and_request_check_core (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bsrc_pkg::APB_AW-1:0]  paddr,
    input  logic [bsrc_pkg::APB_DW-1:0]  pwdata,
    output logic [bsrc_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    // request channel
    input  logic                         start,
    output logic                         busy,
    input  logic [bsrc_pkg::TYPE_W-1:0]  req_type,
    input  logic [bsrc_pkg::PROC_W-1:0]  proc_index,
    input  logic [bsrc_pkg::RES_W-1:0]   res_index,
    input  logic [bsrc_pkg::AMT_W-1:0]   amount,
    // result channel
    output logic                         result_valid,
    output logic [bsrc_pkg::KIND_W-1:0]  result_kind,
    output logic [bsrc_pkg::PROC_W-1:0]  proc_out,
    output logic                         granted,
    output logic                         last
);
    import bsrc_pkg::*;

    // configuration registers
    logic [PCNT_W-1:0] proc_count_reg, proc_count_next;
    logic [RCNT_W-1:0] res_count_reg, res_count_next;

    // sequencer
    bsrc_state_t       state_reg, state_next;
    logic [PROC_W-1:0] p_reg, p_next;
    logic [RES_W-1:0]  r_reg, r_next;
    logic [PCNT_W-1:0] count_reg, count_next;
    logic [PROC_W-1:0] k_reg, k_next;
    logic              found_reg, found_next;

    // small register stores
    logic [NUM_PROCS-1:0] finished_reg, finished_next;
    logic [WORK_W-1:0]    work_reg [NUM_RES];
    logic [WORK_W-1:0]    work_next [NUM_RES];
    logic [AMT_W-1:0]     avail_reg [NUM_RES];
    logic [AMT_W-1:0]     avail_next [NUM_RES];
    logic [AMT_W-1:0]     staged_reg [NUM_RES];
    logic [AMT_W-1:0]     staged_next [NUM_RES];
    logic [PROC_W-1:0]    seq_reg [NUM_PROCS];
    logic [PROC_W-1:0]    seq_next [NUM_PROCS];

    // result registers
    logic              valid_reg, valid_next;
    res_kind_t         kind_reg, kind_next;
    logic [PROC_W-1:0] pout_reg, pout_next;
    logic              grant_reg, grant_next;
    logic              last_reg, last_next;

    // allocation and max-claim memories
    logic [AMT_W-1:0]  alloc_mem [TAB_DEPTH];
    logic [AMT_W-1:0]  max_mem [TAB_DEPTH];
    logic [AMT_W-1:0]  alloc_rd_reg;
    logic [AMT_W-1:0]  max_rd_reg;
    logic              alloc_we;
    logic              max_we;
    logic [ADDR_W-1:0] wr_addr;
    logic [AMT_W-1:0]  wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] in_addr;

    // control terms
    logic              accept;
    logic              cfg_we;
    logic [PCNT_W-1:0] np_act;
    logic [RCNT_W-1:0] nr_act;
    logic [PROC_W-1:0] np_last;
    logic [RES_W-1:0]  nr_last;
    logic              p_is_last;
    logic              r_is_last;
    logic              p_in_ok;
    logic              r_in_ok;
    logic              p_act_ok;
    logic              emit_last;

    bsrc_alu_res_t     alu_res;

    assign accept  = start && !busy;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign busy    = (state_reg != ST_IDLE);

    // active counts, saturated into their legal ranges
    always_comb
    begin
        if (proc_count_reg == '0)
            np_act = PCNT_W'(1);
        else if (proc_count_reg > PCNT_W'(NUM_PROCS))
            np_act = PCNT_W'(NUM_PROCS);
        else
            np_act = proc_count_reg;

        if (res_count_reg == '0)
            nr_act = RCNT_W'(1);
        else if (res_count_reg > RCNT_W'(NUM_RES))
            nr_act = RCNT_W'(NUM_RES);
        else
            nr_act = res_count_reg;
    end

    assign np_last   = PROC_W'(np_act - PCNT_W'(1));
    assign nr_last   = RES_W'(nr_act - RCNT_W'(1));
    assign p_is_last = (p_reg == np_last);
    assign r_is_last = (r_reg == nr_last);
    assign emit_last = (k_reg == np_last);

    assign p_in_ok  = ({1'b0, proc_index} < (PROC_W+1)'(NUM_PROCS));
    assign r_in_ok  = ({1'b0, res_index} < (RES_W+1)'(NUM_RES));
    assign p_act_ok = (PCNT_W'(proc_index) < np_act);

    assign in_addr = ADDR_W'(ADDR_W'(proc_index) * ADDR_W'(NUM_RES) + ADDR_W'(res_index));
    assign rd_addr = ADDR_W'(ADDR_W'(p_reg) * ADDR_W'(NUM_RES) + ADDR_W'(r_reg));

    // register read-back
    always_comb
    begin
        if (paddr[2] == CFG_RES_COUNT)
            prdata = APB_DW'(res_count_reg);
        else
            prdata = APB_DW'(proc_count_reg);
    end

    always_comb
    begin
        proc_count_next = proc_count_reg;
        res_count_next  = res_count_reg;
        if (cfg_we)
        begin
            if (paddr[2] == CFG_PROC_COUNT)
                proc_count_next = pwdata[PCNT_W-1:0];
            else
                res_count_next = pwdata[RCNT_W-1:0];
        end
    end

    // one compare/add unit shared by every element step
    bsrc_alu u_alu (
        .max_val    (max_rd_reg),
        .alloc_val  (alloc_rd_reg),
        .work_val   (work_reg[r_reg]),
        .staged_val (staged_reg[r_reg]),
        .avail_val  (avail_reg[r_reg]),
        .res        (alu_res)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_SAFETY)
                        state_next = ST_SCAN;
                    else if (req_type == REQ_SUBMIT && p_act_ok)
                        state_next = ST_REQ_RD;
                end
            end
            ST_SCAN:
            begin
                if (!finished_reg[p_reg])
                    state_next = ST_FIT_RD;
                else if (p_is_last)
                    state_next = ST_PASS_END;
            end
            ST_FIT_RD:
                state_next = ST_FIT_EV;
            ST_FIT_EV:
            begin
                if (!alu_res.fits)
                    state_next = p_is_last ? ST_PASS_END : ST_SCAN;
                else if (r_is_last)
                    state_next = ST_ADD_RD;
                else
                    state_next = ST_FIT_RD;
            end
            ST_ADD_RD:
                state_next = ST_ADD_EV;
            ST_ADD_EV:
            begin
                if (!r_is_last)
                    state_next = ST_ADD_RD;
                else
                    state_next = p_is_last ? ST_PASS_END : ST_SCAN;
            end
            ST_PASS_END:
            begin
                if (count_reg == np_act)
                    state_next = ST_EMIT;
                else if (!found_reg)
                    state_next = ST_IDLE;
                else
                    state_next = ST_SCAN;
            end
            ST_EMIT:
            begin
                if (emit_last)
                    state_next = ST_IDLE;
            end
            ST_REQ_RD:
                state_next = ST_REQ_EV;
            ST_REQ_EV:
            begin
                if (!alu_res.req_ok)
                    state_next = ST_IDLE;
                else if (r_is_last)
                    state_next = ST_UPD_RD;
                else
                    state_next = ST_REQ_RD;
            end
            ST_UPD_RD:
                state_next = ST_UPD_EV;
            ST_UPD_EV:
                state_next = r_is_last ? ST_IDLE : ST_UPD_RD;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath, memory strobes and results
    always_comb
    begin
        p_next        = p_reg;
        r_next        = r_reg;
        count_next    = count_reg;
        k_next        = k_reg;
        found_next    = found_reg;
        finished_next = finished_reg;
        work_next     = work_reg;
        avail_next    = avail_reg;
        staged_next   = staged_reg;
        seq_next      = seq_reg;

        valid_next = 1'b0;
        kind_next  = kind_reg;
        pout_next  = pout_reg;
        grant_next = grant_reg;
        last_next  = last_reg;

        alloc_we = 1'b0;
        max_we   = 1'b0;
        wr_addr  = in_addr;
        wr_data  = amount;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        REQ_LOAD_ALLOC:
                            alloc_we = p_in_ok && r_in_ok;
                        REQ_LOAD_MAX:
                            max_we = p_in_ok && r_in_ok;
                        REQ_SET_AVAIL:
                        begin
                            if (r_in_ok)
                                avail_next[res_index] = amount;
                        end
                        REQ_SAFETY:
                        begin
                            for (int i = 0; i < NUM_RES; i++)
                                work_next[i] = WORK_W'(avail_reg[i]);
                            finished_next = '0;
                            count_next    = '0;
                            found_next    = 1'b0;
                            p_next        = '0;
                            k_next        = '0;
                        end
                        REQ_STAGE:
                        begin
                            if (r_in_ok)
                                staged_next[res_index] = amount;
                        end
                        REQ_SUBMIT:
                        begin
                            p_next = proc_index;
                            r_next = '0;
                            // process not in use: refused at once
                            if (!p_act_ok)
                            begin
                                valid_next = 1'b1;
                                kind_next  = KIND_REQ;
                                pout_next  = proc_index;
                                grant_next = 1'b0;
                                last_next  = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                r_next = '0;
                if (finished_reg[p_reg] && !p_is_last)
                    p_next = p_reg + PROC_W'(1);
            end
            ST_FIT_EV:
            begin
                if (!alu_res.fits)
                begin
                    if (!p_is_last)
                        p_next = p_reg + PROC_W'(1);
                end
                else if (r_is_last)
                    r_next = '0;
                else
                    r_next = r_reg + RES_W'(1);
            end
            ST_ADD_EV:
            begin
                work_next[r_reg] = alu_res.work_sum;
                if (r_is_last)
                begin
                    finished_next[p_reg]          = 1'b1;
                    seq_next[count_reg[PROC_W-1:0]] = p_reg;
                    count_next                    = count_reg + PCNT_W'(1);
                    found_next                    = 1'b1;
                    if (!p_is_last)
                        p_next = p_reg + PROC_W'(1);
                end
                else
                    r_next = r_reg + RES_W'(1);
            end
            ST_PASS_END:
            begin
                p_next     = '0;
                found_next = 1'b0;
                if (count_reg != np_act && !found_reg)
                begin
                    valid_next = 1'b1;
                    kind_next  = KIND_UNSAFE;
                    pout_next  = '0;
                    grant_next = 1'b0;
                    last_next  = 1'b1;
                end
            end
            ST_EMIT:
            begin
                valid_next = 1'b1;
                kind_next  = KIND_SEQ;
                pout_next  = seq_reg[k_reg];
                grant_next = 1'b0;
                last_next  = emit_last;
                k_next     = k_reg + PROC_W'(1);
            end
            ST_REQ_EV:
            begin
                if (!alu_res.req_ok)
                begin
                    valid_next = 1'b1;
                    kind_next  = KIND_REQ;
                    pout_next  = p_reg;
                    grant_next = 1'b0;
                    last_next  = 1'b1;
                end
                else if (r_is_last)
                    r_next = '0;
                else
                    r_next = r_reg + RES_W'(1);
            end
            ST_UPD_EV:
            begin
                // move the units from available into the allocation
                alloc_we         = 1'b1;
                wr_addr          = rd_addr;
                wr_data          = alu_res.alloc_sum;
                avail_next[r_reg] = alu_res.avail_diff;
                if (r_is_last)
                begin
                    valid_next = 1'b1;
                    kind_next  = KIND_REQ;
                    pout_next  = p_reg;
                    grant_next = 1'b1;
                    last_next  = 1'b1;
                end
                else
                    r_next = r_reg + RES_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    // table memories, registered read
    always_ff @(posedge clk)
    begin
        if (alloc_we)
            alloc_mem[wr_addr] <= wr_data;
        if (max_we)
            max_mem[wr_addr] <= wr_data;
        alloc_rd_reg <= alloc_mem[rd_addr];
        max_rd_reg   <= max_mem[rd_addr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            proc_count_reg <= PCNT_W'(NUM_PROCS);
            res_count_reg  <= RCNT_W'(NUM_RES);
            p_reg          <= '0;
            r_reg          <= '0;
            count_reg      <= '0;
            k_reg          <= '0;
            found_reg      <= 1'b0;
            finished_reg   <= '0;
            valid_reg      <= 1'b0;
            for (int i = 0; i < NUM_RES; i++)
            begin
                work_reg[i]   <= '0;
                staged_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            proc_count_reg <= proc_count_next;
            res_count_reg  <= res_count_next;
            p_reg          <= p_next;
            r_reg          <= r_next;
            count_reg      <= count_next;
            k_reg          <= k_next;
            found_reg      <= found_next;
            finished_reg   <= finished_next;
            valid_reg      <= valid_next;
            work_reg       <= work_next;
            staged_reg     <= staged_next;
        end
    end

    // payload state: available counts, safe sequence and result fields
    always_ff @(posedge clk)
    begin
        avail_reg <= avail_next;
        seq_reg   <= seq_next;
        kind_reg  <= kind_next;
        pout_reg  <= pout_next;
        grant_reg <= grant_next;
        last_reg  <= last_next;
    end

    assign result_valid = valid_reg;
    assign result_kind  = kind_reg;
    assign proc_out     = pout_reg;
    assign granted      = grant_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

// File: src/bsrc_alu.sv
// shared per-element unit: need, fit compare, saturating work add, request check and update
`default_nettype none

module bsrc_alu (
    input  logic [bsrc_pkg::AMT_W-1:0]  max_val,
    input  logic [bsrc_pkg::AMT_W-1:0]  alloc_val,
    input  logic [bsrc_pkg::WORK_W-1:0] work_val,
    input  logic [bsrc_pkg::AMT_W-1:0]  staged_val,
    input  logic [bsrc_pkg::AMT_W-1:0]  avail_val,
    output bsrc_pkg::bsrc_alu_res_t     res
);
    import bsrc_pkg::*;

    logic [AMT_W-1:0]  need;
    logic [WORK_W:0]   sum_wide;

    always_comb
    begin
        // need clamps at zero
        need = (max_val > alloc_val) ? (max_val - alloc_val) : '0;
        sum_wide = {1'b0, work_val} + (WORK_W+1)'(alloc_val);

        res.fits       = (WORK_W'(need) <= work_val);
        res.req_ok     = (staged_val <= need) && (staged_val <= avail_val);
        res.work_sum   = (sum_wide > (WORK_W+1)'(WORK_MAX)) ? WORK_MAX : sum_wide[WORK_W-1:0];
        res.alloc_sum  = alloc_val + staged_val;
        res.avail_diff = avail_val - staged_val;
    end

endmodule

`default_nettype wire

// File: src/bsrc_checker.sv
// port-level checker for the banker's engine and its bind to the top level
`default_nettype none

module bsrc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [bsrc_pkg::TYPE_W-1:0]  req_type,
    input logic                         result_valid,
    input logic [bsrc_pkg::KIND_W-1:0]  result_kind,
    input logic [bsrc_pkg::PROC_W-1:0]  proc_out,
    input logic                         granted,
    input logic                         last
);
    import bsrc_pkg::*;

    // a request verdict is always the only result of its request
    a_req_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_kind == KIND_REQ |-> last)
        else $error("request verdict without last");

    // unsafe verdict is a lone result with cleared fields
    a_unsafe_form: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_kind == KIND_UNSAFE |-> last && proc_out == '0 && !granted)
        else $error("malformed unsafe verdict");

    // safe sequence streams without gaps until its last entry
    a_seq_stream: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |=> result_valid && result_kind == KIND_SEQ)
        else $error("gap inside safe sequence");

    // while the sequence is still streaming the engine refuses new requests
    a_busy_stream: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> busy)
        else $error("idle while sequence pending");

    // a taken safety check always occupies the engine
    a_safety_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req_type == REQ_SAFETY |=> busy)
        else $error("safety check did not start");

endmodule

bind bankers_safety_and_request_check_core bsrc_checker u_bsrc_checker (.*);

`default_nettype wire
